// ===== src/kwm_pkg.sv =====
// ---------------------------------------------------------------------------
// kwm_pkg - K-weighted RMS meter shared definitions
// Item type, filter coefficients and saturation helpers.
// ---------------------------------------------------------------------------
package kwm_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF  = 24;

	localparam int X_BITS = 24;

	typedef struct packed {
		logic signed [X_BITS-1:0] x;
		logic                     last;
	} kwm_item_t;

	typedef struct packed {
		logic      valid;
		kwm_item_t item;
	} kwm_queue_t;

	// coefficient index order: b0, b1, b2, a1, a2 (Q4.28)
	typedef enum logic [2:0] {
		C_B0 = 3'd0,
		C_B1 = 3'd1,
		C_B2 = 3'd2,
		C_A1 = 3'd3,
		C_A2 = 3'd4
	} coef_idx_t;

	function automatic logic signed [31:0] coef(input logic hp, input coef_idx_t idx);
		logic signed [31:0] c;
		c = '0;
		if (!hp) begin
			unique case (idx)
				C_B0: c = 32'sd412081942;
				C_B1: c = -32'sd722546694;
				C_B2: c = 32'sd321691121;
				C_A1: c = -32'sd453832898;
				C_A2: c = 32'sd196623811;
				default: c = '0;
			endcase
		end else begin
			unique case (idx)
				C_B0: c = 32'sd268435456;
				C_B1: c = -32'sd536870912;
				C_B2: c = 32'sd268435456;
				C_A1: c = -32'sd534199296;
				C_A2: c = 32'sd265770496;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
		logic signed [39:0] r;
		if (v > 64'sd549755813887)
			r = 40'sh7fffffffff;
		else if (v < -64'sd549755813888)
			r = 40'sh8000000000;
		else
			r = v[39:0];
		return r;
	endfunction

endpackage

// ===== src/kwm_front.sv =====
// ---------------------------------------------------------------------------
// kwm_front - sample intake
// Scales samples to Q1.23 and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module kwm_front
	import kwm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	output kwm_queue_t                    q,
	input  logic                          pop
);

	logic signed [X_BITS-1:0] x_in;
	kwm_item_t                mem_q [2];
	logic                     wr_q;
	logic                     rd_q;
	logic [1:0]               cnt_q;
	logic                     push;

	generate
		if (SAMPLE_BITS >= X_BITS) begin : g_narrow
			assign x_in = X_BITS'(sample >>> (SAMPLE_BITS - X_BITS));
		end else begin : g_widen
			assign x_in = X_BITS'(sample) <<< (X_BITS - SAMPLE_BITS);
		end
	endgenerate

	assign sample_stall = (cnt_q == 2'd2);
	assign push         = sample_valid && !sample_stall;
	assign q.valid      = (cnt_q != 2'd0);
	assign q.item       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].x    <= x_in;
			mem_q[wr_q].last <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/kwm_back.sv =====
// ---------------------------------------------------------------------------
// kwm_back - filter, accumulate and RMS engine
// One shared multiplier runs both biquads; serial divide and square root.
// ---------------------------------------------------------------------------
module kwm_back
	import kwm_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  kwm_queue_t  q,
	output logic        pop,
	output logic [23:0] rms_level,
	output logic        overflow,
	output logic        result_valid,
	input  logic        result_stall
);

	localparam int CW = COUNT_BITS + 1;

	typedef enum logic [2:0] {
		IDLE, RUN, ACC, DLOAD, DIV, SLOAD, SQRT, DONE
	} state_t;

	state_t             state_q;
	logic [2:0]         ph_q;
	logic               hp_q;
	logic               last_q;
	logic signed [31:0] xin_q;
	logic signed [31:0] y_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] tmp_q;
	logic signed [39:0] d0_q [2];
	logic signed [39:0] d1_q [2];
	logic [63:0]        sum_q;
	logic [CW-1:0]      cnt_q;
	logic               sat_q;
	logic [5:0]         it_q;
	logic [63:0]        quo_q;
	logic [CW-1:0]      rem_q;
	logic [61:0]        src_q;
	logic [33:0]        srem_q;
	logic [30:0]        root_q;

	coef_idx_t          cidx;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] acc;
	logic signed [63:0] diff;
	logic signed [63:0] diff_r;
	logic [64:0]        sum_n;
	logic [CW:0]        dsh;
	logic               dge;
	logic [35:0]        ssh;
	logic [35:0]        strial;
	logic               sge;

	assign pop = (state_q == IDLE) && q.valid;

	always_comb begin
		cidx  = C_B0;
		mul_b = xin_q;
		unique case (ph_q)
			3'd0: cidx = C_B0;
			3'd1: cidx = C_B1;
			3'd2: begin cidx = C_A1; mul_b = y_q; end
			3'd3: cidx = C_B2;
			3'd4: begin cidx = C_A2; mul_b = y_q; end
			default: mul_b = y_q;
		endcase
		mul_a = (ph_q == 3'd5) ? y_q : coef(hp_q, cidx);
	end

	assign mul_p  = mul_a * mul_b;
	assign acc    = prod_q + (64'(d0_q[hp_q]) <<< 19);
	assign diff   = tmp_q - prod_q;
	assign diff_r = (diff + 64'sd262144) >>> 19;
	assign sum_n  = {1'b0, sum_q} + {1'b0, prod_q};
	assign dsh    = {rem_q, quo_q[63]};
	assign dge    = dsh >= {1'b0, cnt_q};
	assign ssh    = {srem_q, src_q[61:60]};
	assign strial = {3'b000, root_q, 2'b01};
	assign sge    = ssh >= strial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			ph_q         <= 3'd0;
			hp_q         <= 1'b0;
			last_q       <= 1'b0;
			d0_q[0]      <= '0;
			d0_q[1]      <= '0;
			d1_q[0]      <= '0;
			d1_q[1]      <= '0;
			sum_q        <= '0;
			cnt_q        <= '0;
			sat_q        <= 1'b0;
			it_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			if (state_q == DONE && (!result_valid || !result_stall))
				result_valid <= 1'b1;
			else if (result_valid && !result_stall)
				result_valid <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (q.valid) begin
						xin_q   <= 32'(q.item.x);
						last_q  <= q.item.last;
						hp_q    <= 1'b0;
						ph_q    <= 3'd0;
						state_q <= RUN;
					end
				end
				RUN: begin
					prod_q <= mul_p;
					ph_q   <= ph_q + 3'd1;
					unique case (ph_q)
						3'd0: ;
						3'd1: y_q <= sat32((acc + 64'sd134217728) >>> 28);
						3'd2: tmp_q <= prod_q;
						3'd3: d0_q[hp_q] <= sat40(diff_r + 64'(d1_q[hp_q]));
						3'd4: tmp_q <= prod_q;
						default: begin
							d1_q[hp_q] <= sat40(diff_r);
							ph_q       <= 3'd0;
							if (!hp_q) begin
								xin_q <= y_q;
								hp_q  <= 1'b1;
							end else begin
								state_q <= ACC;
							end
						end
					endcase
				end
				ACC: begin
					if (cnt_q[COUNT_BITS]) begin
						sat_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						if (sum_n[64]) begin
							sum_q <= '1;
							sat_q <= 1'b1;
						end else begin
							sum_q <= sum_n[63:0];
						end
					end
					state_q <= last_q ? DLOAD : IDLE;
				end
				DLOAD: begin
					quo_q   <= sum_q;
					rem_q   <= '0;
					it_q    <= '0;
					state_q <= DIV;
				end
				DIV: begin
					rem_q <= dge ? CW'(dsh - {1'b0, cnt_q}) : CW'(dsh);
					quo_q <= {quo_q[62:0], dge};
					it_q  <= it_q + 6'd1;
					if (it_q == 6'd63)
						state_q <= SLOAD;
				end
				SLOAD: begin
					src_q   <= quo_q[63:2];
					srem_q  <= '0;
					root_q  <= '0;
					it_q    <= '0;
					state_q <= SQRT;
				end
				SQRT: begin
					srem_q <= sge ? 34'(ssh - strial) : 34'(ssh);
					root_q <= {root_q[29:0], sge};
					src_q  <= {src_q[59:0], 2'b00};
					it_q   <= it_q + 6'd1;
					if (it_q == 6'd30)
						state_q <= DONE;
				end
				default: begin
					if (!result_valid || !result_stall) begin
						rms_level    <= (root_q[30:24] != '0) ? 24'hffffff : root_q[23:0];
						overflow     <= sat_q || (root_q[30:24] != '0);
						d0_q[0]      <= '0;
						d0_q[1]      <= '0;
						d1_q[0]      <= '0;
						d1_q[1]      <= '0;
						sum_q        <= '0;
						cnt_q        <= '0;
						sat_q        <= 1'b0;
						state_q      <= IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== src/k_weighted_rms_meter.sv =====
// Each sample goes from the queue to the running sum through one shared 32x32
// multiplier that does the five products of each of the two biquads and the square;
// a sample marked last then runs the 64-step divider and the 31-step square root
// before the result is registered. A two-item queue in front lets samples arrive
// while the engine works or a result waits.
// ---------------------------------------------------------------------------
// k_weighted_rms_meter - K-weighted block RMS meter
// BS.1770 K-weighting, mean square over a block, square root on the last item.
// ---------------------------------------------------------------------------
module k_weighted_rms_meter
	import kwm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	output logic [23:0]                   rms_level,
	output logic                          overflow,
	output logic                          result_valid,
	input  logic                          result_stall
);

	kwm_queue_t q;
	logic       pop;

	kwm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.last         (last),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.q            (q),
		.pop          (pop)
	);

	kwm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q            (q),
		.pop          (pop),
		.rms_level    (rms_level),
		.overflow     (overflow),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q.valid)
		else $error("pop from empty queue");

	a_full_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> q.valid)
		else $error("queue full but no item offered");

	a_pop_single: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop)
		else $error("engine took two items back to back");

endmodule
